// ----- src/tsp_random_insertion_core_defines.svh -----
// ----------------------------------------------------------------------------
// tsp_random_insertion_core_defines
// Assertion macros shared by the tour builder RTL.
// ----------------------------------------------------------------------------
`ifndef TSP_RANDOM_INSERTION_CORE_DEFINES_SVH
`define TSP_RANDOM_INSERTION_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TSPRI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define TSPRI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/tspri_pkg.sv -----
// ----------------------------------------------------------------------------
// tspri_pkg
// Types and constants of the insertion tour builder.
// ----------------------------------------------------------------------------
package tspri_pkg;

	localparam int MAX_NODES_DEF = 64;
	localparam int COST_BITS_DEF = 24;

	// port field widths
	localparam int OP_W      = 2;
	localparam int NODE_W    = 6;
	localparam int COST_IN_W = 24;
	localparam int STATUS_W  = 2;
	localparam int DELTA_W   = 26;
	localparam int TOTAL_W   = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 7;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE  = 2'd0,
		OP_START  = 2'd1,
		OP_INSERT = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_NODE  = 2'd1,
		STAT_BAD_GUIDE = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GUIDE = 2'd0,
		CFG_FIX   = 2'd1,
		CFG_NODES = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEED,
		S_SEED_END,
		S_INS_PV,
		S_INS_NX,
		S_INS_C1,
		S_INS_C2,
		S_INS_C3,
		S_INS_EVAL,
		S_SHIFT,
		S_PLACE,
		S_RD_ISSUE,
		S_RD_EMIT,
		S_EMIT
	} state_t;

endpackage

// ----- src/tspri_ram.sv -----
// ----------------------------------------------------------------------------
// tspri_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tspri_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/tsp_random_insertion_core.sv -----
// ----------------------------------------------------------------------------
// tsp_random_insertion_core
// Cheapest-position insertion tour builder over a stored asymmetric cost
// matrix, with cost load, tour seeding, node insertion and tour read-out.
// ----------------------------------------------------------------------------
// One command is worked on at a time. A cost write, or any rejected command,
// goes from idle straight to its result beat. A start writes g seed nodes (or
// 2 for a two-node seed) with one cost lookup per seed arc. An insert reads
// the neighbour entries, then scans the positions; the single read port of the
// cost RAM means each position needs three cost lookups, then the tour RAM is
// shifted one entry per cycle down to the chosen position B. A read-out reads
// each tour entry and then gives its beat, waiting while the output is stalled.
// No clearing pass is needed after reset.
module tsp_random_insertion_core
	#(
	parameter int MAX_NODES = tspri_pkg::MAX_NODES_DEF,
	parameter int COST_BITS = tspri_pkg::COST_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tspri_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tspri_pkg::CFG_W-1:0]      cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [tspri_pkg::OP_W-1:0]       operation,
	input  logic [tspri_pkg::NODE_W-1:0]     from_node,
	input  logic [tspri_pkg::NODE_W-1:0]     to_node,
	input  logic [tspri_pkg::COST_IN_W-1:0]  cost_value,
	input  logic [tspri_pkg::NODE_W-1:0]     insert_node,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tspri_pkg::STATUS_W-1:0]   status,
	output logic [tspri_pkg::NODE_W-1:0]     position,
	output logic signed [tspri_pkg::DELTA_W-1:0] delta_cost,
	output logic [tspri_pkg::TOTAL_W-1:0]    total_cost,
	output logic [tspri_pkg::NODE_W-1:0]     tour_node,
	output logic                             last
);

	import tspri_pkg::*;

	`include "tsp_random_insertion_core_defines.svh"

	localparam int NB    = $clog2(MAX_NODES);
	localparam int LB    = $clog2(MAX_NODES + 1);
	localparam int CA_W  = $clog2(MAX_NODES * MAX_NODES);
	localparam int ACC_W = COST_BITS + 7;
	localparam int SUM_W = ((COST_BITS + 3) > 34) ? (COST_BITS + 3) : 34;

	function automatic logic [CA_W-1:0] caddr(input logic [NB-1:0] x, input logic [NB-1:0] y);
		return CA_W'(x) * CA_W'(MAX_NODES) + CA_W'(y);
	endfunction

	// config registers
	logic [CFG_W-1:0] guide_q, nodes_q;
	logic             fix_q;

	// control state
	state_t         state_q, state_d;
	logic [LB-1:0]  tour_len_q;
	logic [TOTAL_W-1:0] tour_total_q;
	logic           out_valid_q;
	logic           sh_vld_s1;

	// working registers
	logic [NB-1:0]  a_q, b_q, r_q, gl_q, pv_q, nx_q;
	logic [NB-1:0]  sh_addr_s1;
	logic           gmode_q, found_q;
	logic [LB-1:0]  cnt_q, k_q, p_q, pend_q, bestp_q;
	logic [COST_BITS-1:0] c1_q, c2_q;
	logic signed [SUM_W-1:0] best_q;
	logic [ACC_W-1:0] acc_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [NODE_W-1:0]   res_pos_q, res_node_q;
	logic signed [DELTA_W-1:0] res_delta_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [NODE_W-1:0]   out_pos_q, out_node_q;
	logic signed [DELTA_W-1:0] out_delta_q;
	logic [TOTAL_W-1:0]  out_total_q;
	logic                out_last_q;

	// memory ports
	logic                 t_we, c_we;
	logic [NB-1:0]        t_waddr, t_raddr, t_wdata, tour_rdata;
	logic [CA_W-1:0]      c_waddr, c_raddr;
	logic [COST_BITS-1:0] c_wdata, cost_rdata;

	// decoded command fields
	logic [CFG_W-1:0] n7, a7, b7, r7, len7;
	logic             a_bad, b_bad, r_bad, out_load;
	logic [LB-1:0]    startp, len_m1, p_p1, k_m1, p_m1;
	logic [NB-1:0]    seed_node, seed_prev, nx_idx, pv_idx;
	logic [COST_BITS-1:0] cv;
	logic signed [SUM_W-1:0] c_w, tot_s, best_clamp;
	logic [ACC_W-1:0] acc_sum;
	logic             take;

	tspri_ram #(.WIDTH(COST_BITS), .DEPTH(MAX_NODES * MAX_NODES)) u_cost_ram (
		.clk  (clk),
		.we   (c_we),
		.waddr(c_waddr),
		.wdata(c_wdata),
		.raddr(c_raddr),
		.rdata(cost_rdata)
	);

	tspri_ram #(.WIDTH(NB), .DEPTH(MAX_NODES)) u_tour_ram (
		.clk  (clk),
		.we   (t_we),
		.waddr(t_waddr),
		.wdata(t_wdata),
		.raddr(t_raddr),
		.rdata(tour_rdata)
	);

	// range checks against the effective node count
	assign n7    = (nodes_q > CFG_W'(MAX_NODES)) ? CFG_W'(MAX_NODES) : nodes_q;
	assign a7    = CFG_W'(from_node);
	assign b7    = CFG_W'(to_node);
	assign r7    = CFG_W'(insert_node);
	assign len7  = CFG_W'(tour_len_q);
	assign a_bad = (a7 >= n7);
	assign b_bad = (b7 >= n7);
	assign r_bad = (r7 >= n7);
	assign cv    = COST_BITS'(32'(cost_value));

	assign startp = (guide_q != '0 && fix_q) ? LB'(2) : '0;
	assign len_m1 = tour_len_q - LB'(1);
	assign p_p1   = p_q + LB'(1);
	assign k_m1   = k_q - LB'(1);
	assign p_m1   = p_q - LB'(1);
	assign nx_idx = (p_q == tour_len_q) ? '0 : p_q[NB-1:0];
	assign pv_idx = (p_q == '0) ? len_m1[NB-1:0] : p_m1[NB-1:0];

	// seed arc endpoints
	assign seed_node = gmode_q ? k_q[NB-1:0] : ((k_q == '0) ? a_q : b_q);
	assign seed_prev = gmode_q ? ((k_q == '0) ? gl_q : k_m1[NB-1:0])
	                           : ((k_q == '0) ? b_q : a_q);
	assign acc_sum   = acc_q + ACC_W'(cost_rdata);

	// insertion cost of the scanned position
	assign c_w  = $signed(SUM_W'(c1_q) + SUM_W'(c2_q) - SUM_W'(cost_rdata));
	assign take = !found_q || (c_w < best_q);
	assign tot_s = $signed(SUM_W'(tour_total_q)) + best_q;
	assign best_clamp = (best_q > $signed(SUM_W'(26'h1FFFFFF))) ? $signed(SUM_W'(26'h1FFFFFF)) :
	                    (best_q < $signed(~SUM_W'(26'h1FFFFFF))) ? $signed(~SUM_W'(26'h1FFFFFF)) :
	                    best_q;

	// next state and memory controls
	always_comb begin
		state_d  = state_q;
		t_we     = 1'b0;
		t_waddr  = '0;
		t_wdata  = '0;
		t_raddr  = '0;
		c_we     = 1'b0;
		c_waddr  = caddr(from_node[NB-1:0], to_node[NB-1:0]);
		c_wdata  = cv;
		c_raddr  = '0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EMIT;
					case (op_t'(operation))
						OP_WRITE: begin
							c_we = !a_bad && !b_bad;
						end
						OP_START: begin
							if (!(guide_q == CFG_W'(1) || guide_q > n7)
							    && !(guide_q == '0 && (a_bad || b_bad || from_node == to_node))) begin
								state_d = S_SEED;
							end
						end
						OP_INSERT: begin
							if (tour_len_q != '0 && !r_bad && len7 < n7) begin
								state_d = S_INS_PV;
							end
						end
						OP_READ: begin
							if (tour_len_q != '0) begin
								state_d = S_RD_ISSUE;
							end
						end
						default: state_d = S_EMIT;
					endcase
				end
			end
			S_SEED: begin
				t_we    = 1'b1;
				t_waddr = k_q[NB-1:0];
				t_wdata = seed_node;
				c_raddr = caddr(seed_prev, seed_node);
				if (k_q == cnt_q - LB'(1)) begin
					state_d = S_SEED_END;
				end
			end
			S_SEED_END: state_d = S_EMIT;
			S_INS_PV: begin
				t_raddr = pv_idx;
				state_d = S_INS_NX;
			end
			S_INS_NX: begin
				t_raddr = nx_idx;
				state_d = S_INS_C1;
			end
			S_INS_C1: begin
				c_raddr = caddr(pv_q, r_q);
				state_d = S_INS_C2;
			end
			S_INS_C2: begin
				c_raddr = caddr(r_q, nx_q);
				state_d = S_INS_C3;
			end
			S_INS_C3: begin
				c_raddr = caddr(pv_q, nx_q);
				state_d = S_INS_EVAL;
			end
			S_INS_EVAL: begin
				if (p_q == pend_q) begin
					state_d = S_SHIFT;
				end else begin
					t_raddr = p_p1[NB-1:0];
					state_d = S_INS_C1;
				end
			end
			S_SHIFT: begin
				if (k_q != bestp_q) begin
					t_raddr = k_m1[NB-1:0];
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				t_we    = 1'b1;
				t_waddr = bestp_q[NB-1:0];
				t_wdata = r_q;
				state_d = S_EMIT;
			end
			S_RD_ISSUE: begin
				t_raddr = k_q[NB-1:0];
				state_d = S_RD_EMIT;
			end
			S_RD_EMIT: begin
				t_raddr  = k_q[NB-1:0];
				out_load = !out_valid_q || out_ready;
				if (out_load) begin
					state_d = (k_q == len_m1) ? S_IDLE : S_RD_ISSUE;
				end
			end
			S_EMIT: begin
				out_load = !out_valid_q || out_ready;
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		// delayed write of a shifted tour entry
		if (sh_vld_s1) begin
			t_we    = 1'b1;
			t_waddr = sh_addr_s1;
			t_wdata = tour_rdata;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers: config, tour length and total, handshakes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guide_q      <= '0;
			fix_q        <= 1'b0;
			nodes_q      <= CFG_W'(64);
			tour_len_q   <= '0;
			tour_total_q <= '0;
			out_valid_q  <= 1'b0;
			sh_vld_s1    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_GUIDE: guide_q <= cfg_data;
					CFG_FIX:   fix_q   <= cfg_data[0];
					CFG_NODES: nodes_q <= cfg_data;
					default:   guide_q <= guide_q;
				endcase
			end
			sh_vld_s1 <= (state_q == S_SHIFT) && (k_q != bestp_q);
			if (state_q == S_SEED_END) begin
				tour_len_q   <= cnt_q;
				tour_total_q <= (40'(acc_sum) > 40'hFFFF_FFFF) ? '1 : TOTAL_W'(acc_sum);
			end
			if (state_q == S_PLACE) begin
				tour_len_q <= tour_len_q + LB'(1);
				if (tot_s < $signed(SUM_W'(0))) begin
					tour_total_q <= '0;
				end else if (tot_s > $signed(SUM_W'(32'hFFFF_FFFF))) begin
					tour_total_q <= '1;
				end else begin
					tour_total_q <= TOTAL_W'(tot_s);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers and result staging
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				a_q          <= from_node[NB-1:0];
				b_q          <= to_node[NB-1:0];
				r_q          <= insert_node[NB-1:0];
				gl_q         <= NB'(guide_q - CFG_W'(1));
				gmode_q      <= (guide_q != '0);
				cnt_q        <= (guide_q == '0) ? LB'(2) : LB'(guide_q);
				k_q          <= '0;
				acc_q        <= '0;
				found_q      <= 1'b0;
				p_q          <= startp;
				pend_q       <= (startp < tour_len_q) ? len_m1 : tour_len_q;
				res_pos_q    <= '0;
				res_delta_q  <= '0;
				res_node_q   <= '0;
				res_status_q <= STAT_OK;
				case (op_t'(operation))
					OP_WRITE: begin
						if (a_bad || b_bad) begin
							res_status_q <= STAT_BAD_NODE;
						end
					end
					OP_START: begin
						if (guide_q == CFG_W'(1) || guide_q > n7) begin
							res_status_q <= STAT_BAD_GUIDE;
						end else if (guide_q == '0
						             && (a_bad || b_bad || from_node == to_node)) begin
							res_status_q <= STAT_BAD_NODE;
						end
					end
					OP_INSERT: begin
						res_node_q <= insert_node;
						if (tour_len_q == '0) begin
							res_status_q <= STAT_BAD_GUIDE;
						end else if (r_bad || len7 >= n7) begin
							res_status_q <= STAT_BAD_NODE;
						end
					end
					OP_READ: begin
						if (tour_len_q == '0) begin
							res_status_q <= STAT_BAD_GUIDE;
						end
					end
					default: res_status_q <= STAT_OK;
				endcase
			end
			S_SEED: begin
				k_q <= k_q + LB'(1);
				if (k_q != '0) begin
					acc_q <= acc_sum;
				end
			end
			S_INS_NX: pv_q <= tour_rdata;
			S_INS_C1: nx_q <= tour_rdata;
			S_INS_C2: c1_q <= cost_rdata;
			S_INS_C3: c2_q <= cost_rdata;
			S_INS_EVAL: begin
				if (take) begin
					best_q  <= c_w;
					bestp_q <= p_q;
				end
				found_q <= 1'b1;
				pv_q    <= nx_q;
				p_q     <= p_p1;
				k_q     <= tour_len_q;
			end
			S_SHIFT: begin
				sh_addr_s1 <= k_q[NB-1:0];
				if (k_q != bestp_q) begin
					k_q <= k_m1;
				end
			end
			S_PLACE: begin
				res_pos_q   <= NODE_W'(bestp_q);
				res_delta_q <= DELTA_W'(best_clamp);
			end
			S_RD_EMIT: begin
				if (out_load) begin
					k_q <= k_q + LB'(1);
				end
			end
			default: k_q <= k_q;
		endcase

		// output beat register
		if (out_load) begin
			out_total_q <= tour_total_q;
			if (state_q == S_RD_EMIT) begin
				out_status_q <= STAT_OK;
				out_pos_q    <= NODE_W'(k_q);
				out_delta_q  <= '0;
				out_node_q   <= NODE_W'(tour_rdata);
				out_last_q   <= (k_q == len_m1);
			end else begin
				out_status_q <= res_status_q;
				out_pos_q    <= res_pos_q;
				out_delta_q  <= res_delta_q;
				out_node_q   <= res_node_q;
				out_last_q   <= 1'b1;
			end
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign position   = out_pos_q;
	assign delta_cost = out_delta_q;
	assign total_cost = out_total_q;
	assign tour_node  = out_node_q;
	assign last       = out_last_q;

	// checks
	`TSPRI_ASSERT_NOW(a_len_bound, 1'b1, tour_len_q <= LB'(MAX_NODES), "tour length over capacity")
	`TSPRI_ASSERT_NEXT(a_place_grows, state_q == S_PLACE, tour_len_q == $past(tour_len_q) + LB'(1), "insert did not grow tour")
	`TSPRI_ASSERT_NOW(a_idle_no_shift, in_ready, !sh_vld_s1, "shift write pending while idle")
	`TSPRI_ASSERT_NOW(a_load_free, out_load, !out_valid_q || out_ready, "result beat overwritten")

endmodule
